// ===== rtl/snft_pkg.sv =====
// Package for the sensor node freshness table: constants, register codes,
// controller states and the command and status groups. Depends on nothing.
package snft_pkg;

  localparam int SUM_W  = 21;
  localparam int Q_W    = 15;
  localparam int DIVD_W = 31;
  localparam int DIVS_W = 16;
  localparam int CNT_W  = 7;

  localparam logic [31:0]    NAN_WORD = 32'h7FC0_0000;
  localparam logic [Q_W-1:0] FULL_Q8  = 15'd25600;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    REG_DRY      = 2'd0,
    REG_WET      = 2'd1,
    REG_TIMEOUT  = 2'd2,
    REG_INTERVAL = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_RD, S_CHK, S_DSTART, S_DWAIT, S_AVG, S_AWAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic chk;
    logic div_start;
    logic node_take;
    logic avg_start;
    logic avg_take;
    logic avg_skip;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic last_node;
    logic div_done;
    logic avg_needed;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [15:0] soil;
    logic [31:0] temp;
    logic [31:0] hum;
    logic [31:0] acc_ms;
  } entry_t;

endpackage

// ===== rtl/snft_ifs.sv =====
// Channel interfaces of the sensor node freshness table: input items,
// result items and configuration writes. Depends on nothing.
interface snft_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] now_ms;
  logic [7:0]  node_id;
  logic        frame_ok;
  logic [15:0] soil_raw;
  logic [31:0] temperature_bits;
  logic [31:0] humidity_bits;
  modport source(output valid, opcode, now_ms, node_id, frame_ok, soil_raw,
                 temperature_bits, humidity_bits, input ready);
  modport sink(input valid, opcode, now_ms, node_id, frame_ok, soil_raw,
               temperature_bits, humidity_bits, output ready);
endinterface

interface snft_out_if;
  logic        valid;
  logic        ready;
  logic        node_ok;
  logic        stored;
  logic        node_online;
  logic        had_new_data;
  logic [15:0] soil_stored;
  logic [31:0] temperature_stored;
  logic [31:0] humidity_stored;
  logic [31:0] stored_time_ms;
  logic [14:0] soil_percent_q8;
  logic [14:0] average_percent_q8;
  logic        average_valid;
  logic [6:0]  online_count;
  modport source(output valid, node_ok, stored, node_online, had_new_data,
                 soil_stored, temperature_stored, humidity_stored, stored_time_ms,
                 soil_percent_q8, average_percent_q8, average_valid, online_count,
                 input ready);
  modport sink(input valid, node_ok, stored, node_online, had_new_data,
               soil_stored, temperature_stored, humidity_stored, stored_time_ms,
               soil_percent_q8, average_percent_q8, average_valid, online_count,
               output ready);
endinterface

interface snft_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/snft_div.sv =====
// Shared restoring divider, one quotient bit per cycle, for quotients below
// 2^15. Depends on snft_pkg.
module snft_div
  import snft_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [Q_W-1:0]    quotient
);

  logic [DIVS_W-1:0] rem_r, rem_nxt, dsr_r;
  logic [Q_W-1:0]    dvd_r, quo_r;
  logic [3:0]        cnt_r;
  logic              busy_r, done_r;
  logic [DIVS_W:0]   trial;
  logic              ge;

  assign trial    = {rem_r, dvd_r[Q_W-1]};
  assign ge       = trial >= {1'b0, dsr_r};
  assign rem_nxt  = ge ? DIVS_W'(trial - {1'b0, dsr_r}) : trial[DIVS_W-1:0];
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIVD_W-1:Q_W];
      dvd_r <= dividend[Q_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[Q_W-2:0], 1'b0};
      quo_r <= {quo_r[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 4'(Q_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/snft_ctrl.sv =====
// Controller of the freshness table: sequences the update, the walk over
// all nodes and the mean division. Depends on snft_pkg.
module snft_ctrl
  import snft_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_UPD;
      S_UPD:    state_nxt = S_RD;
      S_RD:     state_nxt = S_CHK;
      S_CHK: begin
        if (st.need_div) state_nxt = S_DSTART;
        else state_nxt = st.last_node ? S_AVG : S_RD;
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (st.div_done) state_nxt = st.last_node ? S_AVG : S_RD;
      end
      S_AVG:    state_nxt = st.avg_needed ? S_AWAIT : S_OUT;
      S_AWAIT:  if (st.div_done) state_nxt = S_OUT;
      S_OUT:    if (st.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_UPD:    cmd.update = 1'b1;
      S_CHK:    cmd.chk = 1'b1;
      S_DSTART: cmd.div_start = 1'b1;
      S_DWAIT:  cmd.node_take = st.div_done;
      S_AVG: begin
        cmd.avg_start = st.avg_needed;
        cmd.avg_skip  = !st.avg_needed;
      end
      S_AWAIT:  cmd.avg_take = st.div_done;
      S_OUT:    cmd.out_load = st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== rtl/snft_dp.sv =====
// Datapath of the freshness table: configuration registers, node tables,
// walk accumulators, divider and result register. Depends on snft_pkg,
// snft_ifs and snft_div.
module snft_dp
  import snft_pkg::*;
#(
  parameter int NODE_COUNT = 8
)
(
  input  logic         clk,
  input  logic         rst_n,
  snft_in_if.sink      in_bus,
  snft_out_if.source   out_bus,
  snft_cfg_if.sink     cfg_bus,
  input  cmd_t         cmd,
  output status_t      st
);

  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic [15:0] dry_r, wet_r;
  logic [31:0] timeout_r, interval_r;

  logic             op_r, ok_r;
  logic [31:0]      now_r;
  logic [IDX_W-1:0] k_r, in_k, idx_r, rd_addr;
  logic [15:0]      soil_in_r;
  logic [31:0]      temp_in_r, hum_in_r;
  logic [7:0]       id_m1;
  logic             in_ok;

  entry_t      store_mem [NODE_COUNT];
  logic [31:0] recv_mem  [NODE_COUNT];
  logic [NODE_COUNT-1:0] store_vld_r, recv_vld_r, fresh_r;
  entry_t      store_q, cur_entry, new_entry;
  logic [31:0] recv_q, cur_recv;
  logic        store_q_vld, recv_q_vld;

  logic        upd_pkt, store_cond;
  logic        w_ok, w_stored, w_online, w_had_new, avg_vld_r;
  entry_t      w_entry;
  logic [Q_W-1:0]   w_pct, avg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic [DIVD_W-1:0] num_r;

  logic              span_ok, neg, online_i, is_k, diff_pos, diff_big;
  logic [15:0]       span;
  logic signed [16:0] diff;
  logic [Q_W-1:0]    p_imm;

  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dvd;
  logic [DIVS_W-1:0] div_dsr;
  logic [Q_W-1:0]    div_q;
  logic              out_valid_r;

  // Configuration.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_r      <= 16'd4095;
      wet_r      <= 16'd1500;
      timeout_r  <= 32'd10000;
      interval_r <= 32'd300;
    end else if (cfg_bus.valid) begin
      case (reg_idx_t'(cfg_bus.index))
        REG_DRY:      dry_r      <= cfg_bus.data[15:0];
        REG_WET:      wet_r      <= cfg_bus.data[15:0];
        REG_TIMEOUT:  timeout_r  <= cfg_bus.data;
        REG_INTERVAL: interval_r <= cfg_bus.data;
        default:      dry_r      <= dry_r;
      endcase
    end
  end

  // Input capture.
  assign id_m1 = in_bus.node_id - 8'd1;
  assign in_k  = id_m1[IDX_W-1:0];
  assign in_ok = (in_bus.node_id != 8'd0) && ({1'b0, in_bus.node_id} <= 9'(NODE_COUNT))
                 && (in_bus.opcode == OP_QUERY || in_bus.frame_ok);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_bus.opcode;
      now_r     <= in_bus.now_ms;
      k_r       <= in_k;
      ok_r      <= in_ok;
      soil_in_r <= in_bus.soil_raw;
      temp_in_r <= in_bus.temperature_bits;
      hum_in_r  <= in_bus.humidity_bits;
    end
  end

  // Node tables; an entry never written reads as its reset value.
  assign rd_addr = cmd.accept ? in_k : idx_r;

  always_ff @(posedge clk) begin
    store_q     <= store_mem[rd_addr];
    recv_q      <= recv_mem[rd_addr];
    store_q_vld <= store_vld_r[rd_addr];
    recv_q_vld  <= recv_vld_r[rd_addr];
  end

  assign cur_entry = store_q_vld ? store_q : '{soil: 16'd0, temp: NAN_WORD,
                                               hum: NAN_WORD, acc_ms: 32'd0};
  assign cur_recv  = recv_q_vld ? recv_q : 32'd0;
  assign upd_pkt   = cmd.update && ok_r && (op_r == OP_PACKET);
  assign store_cond = (now_r - cur_entry.acc_ms) >= interval_r;
  assign new_entry = '{soil: soil_in_r, temp: temp_in_r, hum: hum_in_r, acc_ms: now_r};

  always_ff @(posedge clk) begin
    if (upd_pkt) begin
      recv_mem[k_r] <= now_r;
      if (store_cond) begin
        store_mem[k_r] <= new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_vld_r <= '0;
      recv_vld_r  <= '0;
      fresh_r     <= '0;
    end else if (cmd.update && ok_r) begin
      if (op_r == OP_PACKET) begin
        recv_vld_r[k_r] <= 1'b1;
        fresh_r[k_r]    <= 1'b1;
        if (store_cond) store_vld_r[k_r] <= 1'b1;
      end else begin
        fresh_r[k_r] <= 1'b0;
      end
    end
  end

  // Walk over the nodes.
  assign span_ok  = dry_r != wet_r;
  assign neg      = dry_r < wet_r;
  assign span     = neg ? (wet_r - dry_r) : (dry_r - wet_r);
  assign diff     = neg ? ($signed({1'b0, cur_entry.soil}) - $signed({1'b0, dry_r}))
                        : ($signed({1'b0, dry_r}) - $signed({1'b0, cur_entry.soil}));
  assign diff_pos = !diff[16] && (diff != 17'sd0);
  assign diff_big = diff >= $signed({1'b0, span});
  assign p_imm    = (diff_pos && diff_big) ? FULL_Q8 : '0;
  assign online_i = (now_r - cur_recv) < timeout_r;
  assign is_k     = ok_r && (idx_r == k_r);

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      w_ok      <= ok_r;
      w_stored  <= upd_pkt && store_cond;
      w_had_new <= ok_r && (op_r == OP_QUERY) && fresh_r[k_r];
      w_online  <= 1'b0;
      w_pct     <= '0;
      idx_r     <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      if (!ok_r) begin
        w_entry <= '{soil: 16'd0, temp: NAN_WORD, hum: NAN_WORD, acc_ms: 32'd0};
      end else if (upd_pkt && store_cond) begin
        w_entry <= new_entry;
      end else begin
        w_entry <= cur_entry;
      end
    end else if (cmd.chk) begin
      num_r <= {16'd0, FULL_Q8} * {15'd0, diff[15:0]};
      if (is_k) w_online <= online_i;
      if (online_i) cnt_r <= cnt_r + 7'd1;
      if (!st.need_div) begin
        idx_r <= idx_r + 1'b1;
        if (online_i && span_ok) sum_r <= sum_r + SUM_W'(p_imm);
        if (is_k && online_i && span_ok) w_pct <= p_imm;
      end
    end else if (cmd.node_take) begin
      idx_r <= idx_r + 1'b1;
      sum_r <= sum_r + SUM_W'(div_q);
      if (is_k) w_pct <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_take) begin
      avg_r     <= div_q;
      avg_vld_r <= 1'b1;
    end else if (cmd.avg_skip) begin
      avg_r     <= '0;
      avg_vld_r <= 1'b0;
    end
  end

  // Shared divider.
  assign div_start = cmd.div_start || cmd.avg_start;
  assign div_dvd   = cmd.avg_start ? DIVD_W'(sum_r) : num_r;
  assign div_dsr   = cmd.avg_start ? DIVS_W'(cnt_r) : span;

  snft_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  // Status.
  assign st.need_div   = online_i && span_ok && diff_pos && !diff_big;
  assign st.last_node  = idx_r == IDX_W'(NODE_COUNT - 1);
  assign st.div_done   = div_done;
  assign st.avg_needed = (cnt_r != '0) && span_ok;
  assign st.out_free   = !out_valid_r || out_bus.ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bus.node_ok            <= w_ok;
      out_bus.stored             <= w_stored;
      out_bus.node_online        <= w_online;
      out_bus.had_new_data       <= w_had_new;
      out_bus.soil_stored        <= w_entry.soil;
      out_bus.temperature_stored <= w_entry.temp;
      out_bus.humidity_stored    <= w_entry.hum;
      out_bus.stored_time_ms     <= w_entry.acc_ms;
      out_bus.soil_percent_q8    <= w_pct;
      out_bus.average_percent_q8 <= avg_r;
      out_bus.average_valid      <= avg_vld_r;
      out_bus.online_count       <= cnt_r;
    end
  end

  assign out_bus.valid = out_valid_r;

endmodule

// ===== rtl/sensor_node_freshness_table_unit.sv =====
// Top level of the sensor node freshness table: joins controller and datapath.
// Depends on snft_pkg, snft_ifs, snft_ctrl and snft_dp.
//
// One item is handled at a time. The item is accepted in the idle state and the
// node update follows in the update state. Then every node is visited in turn: a
// read and a check state for a node that is offline or whose percent clamps, or
// when dry equals wet, and in addition a start and a wait state on the shared
// 15-step divider for a node whose percent needs a division. The mean is then
// divided in the same divider, or skipped when no node is online or dry equals wet.
// The result register is then loaded; an item is held up only while an earlier
// result still waits in the output register. The next item is taken while the
// previous result waits in the output register.
module sensor_node_freshness_table_unit
  import snft_pkg::*;
#(
  parameter int NODE_COUNT = 8
)
(
  input  logic       clk,
  input  logic       rst_n,
  snft_in_if.sink    in_bus,
  snft_out_if.source out_bus,
  snft_cfg_if.sink   cfg_bus
);

  cmd_t    cmd;
  status_t st;

  snft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .st       (st),
    .cmd      (cmd)
  );

  snft_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus),
    .cmd     (cmd),
    .st      (st)
  );

endmodule

// ===== dv/tb_sensor_node_freshness_table_unit.sv =====
// Testbench for sensor_node_freshness_table_unit: directed table, then random packets
// and queries under several calibration settings, checked against a local predictor.
// Depends on snft_pkg, snft_ifs and the block's RTL.
`timescale 1ns / 1ps

module tb_sensor_node_freshness_table_unit;
  import snft_pkg::*;

  localparam int NODES = 8;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic [7:0]  id;
    logic        frame;
    logic [15:0] soil;
    logic [31:0] temp;
    logic [31:0] hum;
  } node_item_t;

  typedef struct packed {
    logic        node_ok;
    logic        stored;
    logic        online;
    logic        had_new;
    logic [15:0] soil;
    logic [31:0] temp;
    logic [31:0] hum;
    logic [31:0] stime;
    logic [14:0] pct;
    logic [14:0] avg;
    logic        avg_valid;
    logic [6:0]  count;
  } node_result_t;

  typedef struct packed {
    node_item_t   item;
    logic         fixed;
    node_result_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  snft_in_if  in_if();
  snft_out_if out_if();
  snft_cfg_if cfg_if();

  sensor_node_freshness_table_unit #(.NODE_COUNT(NODES)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_if), .out_bus(out_if), .cfg_bus(cfg_if)
  );

  always #5 clk = ~clk;

  logic [31:0] cal_dry, cal_wet, cal_timeout, cal_interval;
  logic [15:0] tab_soil [NODES];
  logic [31:0] tab_temp [NODES];
  logic [31:0] tab_hum [NODES];
  logic [31:0] tab_stime [NODES];
  logic [31:0] tab_rx [NODES];
  logic [31:0] tab_acc [NODES];
  logic        tab_fresh [NODES];

  node_result_t awaited_results[$];
  table_row_t   directed_rows[$];
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;
  logic [31:0] clock_ms = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic is_live(int k, logic [31:0] now);
    logic [31:0] d;
    d = now - tab_rx[k];
    return d < cal_timeout;
  endfunction

  function automatic logic [14:0] node_percent(int k);
    longint span, num, q;
    span = longint'(cal_dry) - longint'(cal_wet);
    num = 64'sd25600 * (longint'(cal_dry) - longint'(tab_soil[k]));
    if (span < 0) begin
      span = -span;
      num = -num;
    end
    if (num <= 0) return 15'd0;
    q = num / span;
    if (q > 25600) q = 25600;
    return q[14:0];
  endfunction

  function automatic node_result_t predict_node(node_item_t it);
    node_result_t r;
    int k;
    logic id_ok, ok, span_ok;
    logic [31:0] d, sum;
    int count;
    r = '0;
    r.temp = NAN_WORD;
    r.hum = NAN_WORD;
    id_ok = it.id >= 1 && it.id <= NODES;
    ok = id_ok && (it.op == OP_QUERY || it.frame);
    span_ok = cal_dry != cal_wet;
    if (ok) begin
      k = it.id - 1;
      if (it.op == OP_PACKET) begin
        tab_fresh[k] = 1'b1;
        tab_rx[k] = it.now;
        d = it.now - tab_acc[k];
        if (d >= cal_interval) begin
          tab_acc[k] = it.now;
          tab_soil[k] = it.soil;
          tab_temp[k] = it.temp;
          tab_hum[k] = it.hum;
          tab_stime[k] = it.now;
          r.stored = 1'b1;
        end
      end else begin
        r.had_new = tab_fresh[k];
        tab_fresh[k] = 1'b0;
      end
      r.node_ok = 1'b1;
      r.online = is_live(k, it.now);
      r.soil = tab_soil[k];
      r.temp = tab_temp[k];
      r.hum = tab_hum[k];
      r.stime = tab_stime[k];
      if (r.online && span_ok) r.pct = node_percent(k);
    end
    sum = 0;
    count = 0;
    for (int i = 0; i < NODES; i++) begin
      if (is_live(i, it.now)) begin
        count++;
        if (span_ok) sum += node_percent(i);
      end
    end
    if (count > 0 && span_ok) begin
      r.avg = 15'(sum / count);
      r.avg_valid = 1'b1;
    end
    r.count = 7'(count);
    return r;
  endfunction

  task automatic reset_model();
    cal_dry = 4095;
    cal_wet = 1500;
    cal_timeout = 10000;
    cal_interval = 300;
    for (int i = 0; i < NODES; i++) begin
      tab_soil[i] = 0;
      tab_temp[i] = NAN_WORD;
      tab_hum[i] = NAN_WORD;
      tab_stime[i] = 0;
      tab_rx[i] = 0;
      tab_acc[i] = 0;
      tab_fresh[i] = 1'b0;
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_DRY:      cal_dry = {16'd0, value[15:0]};
      REG_WET:      cal_wet = {16'd0, value[15:0]};
      REG_TIMEOUT:  cal_timeout = value;
      REG_INTERVAL: cal_interval = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_item(node_item_t it, logic fixed, node_result_t want);
    node_result_t r;
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.opcode = it.op;
    in_if.now_ms = it.now;
    in_if.node_id = it.id;
    in_if.frame_ok = it.frame;
    in_if.soil_raw = it.soil;
    in_if.temperature_bits = it.temp;
    in_if.humidity_bits = it.hum;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    r = predict_node(it);
    awaited_results.push_back(fixed ? want : r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic node_item_t mk(logic op, logic [31:0] now, logic [7:0] id, logic frame,
                                    logic [15:0] soil, logic [31:0] temp, logic [31:0] hum);
    node_item_t it;
    it = '{op: op, now: now, id: id, frame: frame, soil: soil, temp: temp, hum: hum};
    return it;
  endfunction

  function automatic node_item_t random_item();
    node_item_t it;
    int lo, hi;
    if ($urandom_range(0, 29) == 0) clock_ms += $urandom;
    else clock_ms += $urandom_range(0, 400);
    it.now = clock_ms;
    it.op = 1'($urandom_range(0, 1));
    it.id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, NODES));
    it.frame = $urandom_range(0, 11) != 0;
    lo = (cal_dry < cal_wet) ? cal_dry : cal_wet;
    hi = (cal_dry < cal_wet) ? cal_wet : cal_dry;
    lo = (lo > 200) ? lo - 200 : 0;
    hi = (hi < 65335) ? hi + 200 : 65535;
    it.soil = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(lo, hi));
    it.temp = $urandom;
    it.hum = $urandom;
    return it;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      send_item(random_item(), 1'b0, '0);
      if ($urandom_range(0, 149) == 0) wait_idle();
    end
    wait_idle();
  endtask

  always @(negedge clk) begin : result_sink
    static int mode = 0;
    static int mode_left = 0;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    case (mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= $urandom_range(0, 3) != 0;
      default: out_if.ready <= $urandom_range(0, 9) == 0;
    endcase
  end

  always @(posedge clk) begin : result_check
    node_result_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        report("unexpected beat", 32'd0, 32'd0);
      end else begin
        w = awaited_results.pop_front();
        if (out_if.node_ok !== w.node_ok) report("node_ok", out_if.node_ok, w.node_ok);
        if (out_if.stored !== w.stored) report("stored", out_if.stored, w.stored);
        if (out_if.node_online !== w.online) report("node_online", out_if.node_online, w.online);
        if (out_if.had_new_data !== w.had_new) report("had_new_data", out_if.had_new_data, w.had_new);
        if (out_if.soil_stored !== w.soil) report("soil_stored", out_if.soil_stored, w.soil);
        if (out_if.temperature_stored !== w.temp)
          report("temperature_stored", out_if.temperature_stored, w.temp);
        if (out_if.humidity_stored !== w.hum)
          report("humidity_stored", out_if.humidity_stored, w.hum);
        if (out_if.stored_time_ms !== w.stime)
          report("stored_time_ms", out_if.stored_time_ms, w.stime);
        if (out_if.soil_percent_q8 !== w.pct)
          report("soil_percent_q8", out_if.soil_percent_q8, w.pct);
        if (out_if.average_percent_q8 !== w.avg)
          report("average_percent_q8", out_if.average_percent_q8, w.avg);
        if (out_if.average_valid !== w.avg_valid)
          report("average_valid", out_if.average_valid, w.avg_valid);
        if (out_if.online_count !== w.count)
          report("online_count", out_if.online_count, w.count);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_row(node_item_t it, logic fixed, node_result_t want);
    directed_rows.push_back('{item: it, fixed: fixed, want: want});
  endtask

  initial begin : stimulus
    node_result_t idle_res, live_res;
    in_if.valid = 1'b0;
    in_if.opcode = OP_PACKET;
    in_if.now_ms = '0;
    in_if.node_id = '0;
    in_if.frame_ok = 1'b0;
    in_if.soil_raw = '0;
    in_if.temperature_bits = '0;
    in_if.humidity_bits = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DRY;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Right after reset every node is online with a zero reading, which clamps to full scale.
    idle_res = '{0, 0, 0, 0, 16'd0, NAN_WORD, NAN_WORD, 32'd0, 15'd0, 15'd25600, 1, 7'd8};
    live_res = '{1, 0, 1, 0, 16'd0, NAN_WORD, NAN_WORD, 32'd0, 15'd25600, 15'd25600, 1, 7'd8};
    add_row(mk(OP_QUERY, 0, 0, 1, 0, 0, 0), 1, idle_res);
    add_row(mk(OP_PACKET, 1, 9, 1, 16'hFFFF, 0, 0), 1, idle_res);
    add_row(mk(OP_PACKET, 2, 1, 0, 16'h1234, 0, 0), 1, idle_res);
    add_row(mk(OP_QUERY, 3, 255, 0, 0, 0, 0), 1, idle_res);
    add_row(mk(OP_QUERY, 4, 1, 0, 0, 0, 0), 1, live_res);
    add_row(mk(OP_PACKET, 10, 1, 1, 4095, 32'hFFFF_FFFF, 0), 1, live_res);
    add_row(mk(OP_PACKET, 400, 1, 1, 4095, 32'hFFFF_FFFF, 0), 0, '0);
    add_row(mk(OP_QUERY, 410, 1, 1, 0, 0, 0), 0, '0);
    add_row(mk(OP_QUERY, 420, 1, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_PACKET, 500, 8, 1, 16'hFFFF, 0, 32'hFFFF_FFFF), 0, '0);
    add_row(mk(OP_PACKET, 600, 2, 1, 1500, 32'h3F80_0000, 32'h4248_0000), 0, '0);
    add_row(mk(OP_PACKET, 700, 3, 1, 2000, 32'h0, 32'h8000_0000), 0, '0);
    add_row(mk(OP_PACKET, 800, 4, 1, 0, 32'h1, 32'h2), 0, '0);
    add_row(mk(OP_PACKET, 9999, 5, 1, 3000, 32'h5, 32'h6), 0, '0);
    add_row(mk(OP_QUERY, 10600, 8, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_PACKET, 32'hFFFF_FF00, 6, 1, 2500, 32'hAAAA_5555, 32'h5555_AAAA), 0, '0);
    add_row(mk(OP_PACKET, 32'h0000_0100, 6, 1, 2600, 32'h7, 32'h8), 0, '0);
    add_row(mk(OP_QUERY, 32'h0000_0110, 6, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_QUERY, 32'h8000_0000, 7, 1, 0, 0, 0), 0, '0);
    add_row(mk(OP_PACKET, 32'h8000_0001, 8, 0, 16'hFFFF, 0, 0), 0, '0);
    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].fixed,
                                         directed_rows[i].want);
    wait_idle();
    clock_ms = 32'h8000_0100;
    random_phase(300);

    write_reg(REG_DRY, 32'd0);
    write_reg(REG_WET, 32'h0000_FFFF);
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_INTERVAL, 32'd0);
    random_phase(300);

    write_reg(REG_DRY, 32'h0000_FFFF);
    write_reg(REG_WET, 32'd0);
    write_reg(REG_TIMEOUT, 32'd2000);
    write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
    random_phase(250);

    write_reg(REG_DRY, 32'd1234);
    write_reg(REG_WET, 32'd1234);
    write_reg(REG_TIMEOUT, 32'd0);
    random_phase(150);
    write_reg(REG_TIMEOUT, 32'd5000);
    random_phase(150);

    write_reg(REG_DRY, $urandom_range(2000, 4000));
    write_reg(REG_WET, $urandom_range(500, 1999));
    write_reg(REG_TIMEOUT, $urandom_range(500, 5000));
    write_reg(REG_INTERVAL, $urandom_range(0, 600));
    random_phase(300);

    write_reg(REG_DRY, $urandom);
    write_reg(REG_WET, $urandom);
    write_reg(REG_TIMEOUT, $urandom_range(1, 20000));
    write_reg(REG_INTERVAL, $urandom_range(0, 1000));
    random_phase(200);

    write_reg(REG_DRY, 32'd4095);
    write_reg(REG_WET, 32'd1500);
    write_reg(REG_TIMEOUT, 32'd10000);
    write_reg(REG_INTERVAL, 32'd300);
    random_phase(250);

    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
